[sv/npl_pkg.sv]
// Shared constants, codes and types for the nearest-point pipeline.
package npl_pkg;

   localparam int LANES       = 3;
   localparam int COORD_W     = 20;
   localparam int UNIT_W      = 20;
   localparam int UNIT_FRAC   = 18;
   localparam int RADIUS_W    = COORD_W - 1;
   localparam int THR_W       = 40;
   localparam int PACK_W      = 60;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int NORM_GUARD  = 4;

   // datapath widths
   localparam int D_W     = COORD_W + 1;
   localparam int PROD_W  = D_W + UNIT_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int T_W     = DOT_W - UNIT_FRAC;
   localparam int AT_W    = UNIT_W + T_W;
   localparam int RAT_W   = AT_W - UNIT_FRAC;
   localparam int Q_W     = RAT_W + 1;
   localparam int SQ_W    = 2 * Q_W;
   localparam int M_W     = SQ_W;
   localparam int RAD_W   = M_W + 2 * NORM_GUARD;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int XR_W    = UNIT_W + RADIUS_W + 1;
   localparam int QR_W    = Q_W + RADIUS_W + 1;
   localparam int QUO_W   = RADIUS_W + 1;
   localparam int NUM_W   = ROOT_W + QUO_W;
   localparam int RES_W   = Q_W + 1;

   localparam int PROJ_STAGES = 7;

   localparam logic [KIND_W-1:0] KIND_LINE   = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_CIRCLE = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_PLANE  = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_NONE   = KIND_W'(3);

   localparam logic [STATUS_W-1:0] ST_NORMAL = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_ONAXIS = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_UNSUP  = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_SAT    = STATUS_W'(3);

   localparam logic [CSR_ADDR_W-1:0] CSR_KIND   = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_ORIGIN = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_AXIS   = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_XAXIS  = CSR_ADDR_W'(3);
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS = CSR_ADDR_W'(4);
   localparam logic [CSR_ADDR_W-1:0] CSR_THR    = CSR_ADDR_W'(5);

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] near_x;
      logic signed [COORD_W-1:0] near_y;
      logic signed [COORD_W-1:0] near_z;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [PACK_W-1:0]   origin;
      logic [PACK_W-1:0]   axis;
      logic [PACK_W-1:0]   xaxis;
      logic [RADIUS_W-1:0] radius;
      logic [THR_W-1:0]    thr;
   } cfg_type;

   // rides along the square-root pipe
   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] num;
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][RES_W-1:0] lp;
      logic [LANES-1:0][RES_W-1:0] fb;
      logic                        on_axis;
   } sqrt_side_type;

   // rides along the divider pipe
   typedef struct packed {
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][RES_W-1:0] lp;
      logic [LANES-1:0][RES_W-1:0] fb;
      logic                        fallback;
   } div_side_type;

endpackage

[sv/npl_proj.sv]
// Projection front end: offset, dot product, axis removal, squared norm, line/plane result and circle numerators.
module npl_proj (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  npl_pkg::req_type      in_data,
   input  npl_pkg::cfg_type      cfg,
   output logic                  out_valid,
   output logic [npl_pkg::M_W-1:0] out_m,
   output npl_pkg::sqrt_side_type  out_side
);
   import npl_pkg::*;

   localparam logic signed [XR_W-1:0]  XR_HALF  = XR_W'(2 ** (UNIT_FRAC - 1));
   localparam logic signed [AT_W-1:0]  AT_HALF  = AT_W'(2 ** (UNIT_FRAC - 1));
   localparam logic signed [DOT_W-1:0] DOT_HALF = DOT_W'(2 ** (UNIT_FRAC - 1));

   logic [PROJ_STAGES-1:0] v_ff;

   logic signed [COORD_W-1:0] pt  [LANES];
   logic signed [COORD_W-1:0] o_c [LANES];
   logic signed [UNIT_W-1:0]  a_c [LANES];
   logic signed [UNIT_W-1:0]  x_c [LANES];
   logic signed [RADIUS_W:0]  r_c;

   logic signed [XR_W-1:0]          xr_bias [LANES];
   logic signed [XR_W-UNIT_FRAC-1:0] xr_rnd [LANES];
   logic signed [AT_W-1:0]          at_bias [LANES];
   logic signed [RAT_W-1:0]         rat     [LANES];
   logic [QR_W-1:0]                 qr_abs  [LANES];
   logic signed [DOT_W-1:0]         dot_sum;
   logic [M_W-1:0]                  m_sum;

   logic signed [D_W-1:0]     d1_ff [LANES], d2_ff [LANES], d3_ff [LANES], d4_ff [LANES];
   logic signed [COORD_W-1:0] p1_ff [LANES], p2_ff [LANES], p3_ff [LANES], p4_ff [LANES];
   logic signed [XR_W-1:0]    xr1_ff [LANES];
   logic signed [PROD_W-1:0]  prod2_ff [LANES];
   logic signed [RES_W-1:0]   fb2_ff [LANES], fb3_ff [LANES], fb4_ff [LANES];
   logic signed [RES_W-1:0]   fb5_ff [LANES], fb6_ff [LANES], fb7_ff [LANES];
   logic signed [T_W-1:0]     t3_ff;
   logic signed [AT_W-1:0]    at4_ff [LANES];
   logic signed [Q_W-1:0]     q5_ff [LANES];
   logic signed [RES_W-1:0]   lp5_ff [LANES], lp6_ff [LANES], lp7_ff [LANES];
   logic [SQ_W-1:0]           sq6_ff [LANES];
   logic signed [QR_W-1:0]    qr6_ff [LANES];
   logic [M_W-1:0]            m7_ff;
   logic                      on7_ff;
   logic [NUM_W-1:0]          num7_ff [LANES];
   logic                      neg7_ff [LANES];

   always_comb begin
      pt[0] = in_data.point_x;
      pt[1] = in_data.point_y;
      pt[2] = in_data.point_z;
      r_c   = {1'b0, cfg.radius};
      for (int i = 0; i < LANES; i++) begin
         o_c[i]     = cfg.origin[i*COORD_W +: COORD_W];
         a_c[i]     = cfg.axis[i*UNIT_W +: UNIT_W];
         x_c[i]     = cfg.xaxis[i*UNIT_W +: UNIT_W];
         xr_bias[i] = xr1_ff[i] + XR_HALF;
         xr_rnd[i]  = xr_bias[i][XR_W-1:UNIT_FRAC];
         at_bias[i] = at4_ff[i] + AT_HALF;
         rat[i]     = at_bias[i][AT_W-1:UNIT_FRAC];
         qr_abs[i]  = qr6_ff[i][QR_W-1] ? -qr6_ff[i] : qr6_ff[i];
      end
      dot_sum = DOT_W'(prod2_ff[0]) + DOT_W'(prod2_ff[1]) + DOT_W'(prod2_ff[2]) + DOT_HALF;
      m_sum   = sq6_ff[0] + sq6_ff[1] + sq6_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[PROJ_STAGES-2:0], in_valid};
      end
      t3_ff  <= dot_sum[DOT_W-1:UNIT_FRAC];
      m7_ff  <= m_sum;
      on7_ff <= m_sum < M_W'(cfg.thr);
      for (int i = 0; i < LANES; i++) begin
         d1_ff[i]    <= pt[i] - o_c[i];
         p1_ff[i]    <= pt[i];
         xr1_ff[i]   <= x_c[i] * r_c;
         prod2_ff[i] <= d1_ff[i] * a_c[i];
         d2_ff[i]    <= d1_ff[i];
         p2_ff[i]    <= p1_ff[i];
         fb2_ff[i]   <= RES_W'(o_c[i]) + RES_W'(xr_rnd[i]);
         d3_ff[i]    <= d2_ff[i];
         p3_ff[i]    <= p2_ff[i];
         fb3_ff[i]   <= fb2_ff[i];
         at4_ff[i]   <= a_c[i] * t3_ff;
         d4_ff[i]    <= d3_ff[i];
         p4_ff[i]    <= p3_ff[i];
         fb4_ff[i]   <= fb3_ff[i];
         q5_ff[i]    <= d4_ff[i] - rat[i];
         lp5_ff[i]   <= (cfg.kind == KIND_LINE) ? RES_W'(o_c[i]) + RES_W'(rat[i])
                                                : RES_W'(p4_ff[i]) - RES_W'(rat[i]);
         fb5_ff[i]   <= fb4_ff[i];
         sq6_ff[i]   <= q5_ff[i] * q5_ff[i];
         qr6_ff[i]   <= q5_ff[i] * r_c;
         lp6_ff[i]   <= lp5_ff[i];
         fb6_ff[i]   <= fb5_ff[i];
         neg7_ff[i]  <= qr6_ff[i][QR_W-1];
         num7_ff[i]  <= NUM_W'({qr_abs[i], {NORM_GUARD{1'b0}}});
         lp7_ff[i]   <= lp6_ff[i];
         fb7_ff[i]   <= fb6_ff[i];
      end
   end

   always_comb begin
      out_valid        = v_ff[PROJ_STAGES-1];
      out_m            = m7_ff;
      out_side.on_axis = on7_ff;
      for (int i = 0; i < LANES; i++) begin
         out_side.num[i] = num7_ff[i];
         out_side.neg[i] = neg7_ff[i];
         out_side.lp[i]  = lp7_ff[i];
         out_side.fb[i]  = fb7_ff[i];
      end
   end

endmodule

[sv/npl_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module npl_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [npl_pkg::RAD_W-1:0]   in_rad,
   input  npl_pkg::sqrt_side_type      in_side,
   output logic                        out_valid,
   output logic [npl_pkg::ROOT_W-1:0]  out_root,
   output npl_pkg::sqrt_side_type      out_side
);
   import npl_pkg::*;

   logic [ROOT_W-1:0] v_ff;
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   sqrt_side_type     side_ff [ROOT_W];

   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [RAD_W-1:0]  rad_in  [ROOT_W];

   always_comb begin
      for (int s = 0; s < ROOT_W; s++) begin
         logic [REM_W-1:0]  rem_prev;
         logic [REM_W-1:0]  rem_sh;
         logic [REM_W-1:0]  trial;
         logic [ROOT_W-1:0] root_prev;
         logic [RAD_W-1:0]  rad_prev;
         if (s == 0) begin
            rem_prev  = '0;
            root_prev = '0;
            rad_prev  = in_rad;
         end else begin
            rem_prev  = rem_ff[s-1];
            root_prev = root_ff[s-1];
            rad_prev  = rad_ff[s-1];
         end
         // bring down the next radicand pair, try 4*root + 1
         rem_sh    = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
         trial     = {root_prev, 2'b01};
         rad_in[s] = rad_prev << 2;
         if (rem_sh >= trial) begin
            rem_in[s]  = rem_sh - trial;
            root_in[s] = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = rem_sh;
            root_in[s] = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[ROOT_W-2:0], in_valid};
      end
      for (int s = 0; s < ROOT_W; s++) begin
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         rad_ff[s]  <= rad_in[s];
         if (s == 0) begin
            side_ff[s] <= in_side;
         end else begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

[sv/npl_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor, rounding to nearest.
module npl_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [npl_pkg::ROOT_W-1:0] in_root,
   input  npl_pkg::sqrt_side_type     in_side,
   output logic                       out_valid,
   output logic [npl_pkg::LANES-1:0][npl_pkg::QUO_W-1:0] out_quo,
   output npl_pkg::div_side_type      out_side
);
   import npl_pkg::*;

   logic              e_v_ff;
   logic [NUM_W-1:0]  e_n_ff [LANES];
   logic [ROOT_W-1:0] e_g_ff;
   div_side_type      e_side_ff;

   logic [QUO_W-1:0]  v_ff;
   logic [ROOT_W-1:0] rem_ff  [QUO_W][LANES];
   logic [QUO_W-1:0]  w_ff    [QUO_W][LANES];
   logic [ROOT_W-1:0] g_ff    [QUO_W];
   div_side_type      side_ff [QUO_W];

   logic [ROOT_W-1:0] rem_in [QUO_W][LANES];
   logic [QUO_W-1:0]  w_in   [QUO_W][LANES];

   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         for (int l = 0; l < LANES; l++) begin
            logic [ROOT_W-1:0] rem_prev;
            logic [QUO_W-1:0]  w_prev;
            logic [ROOT_W-1:0] g_prev;
            logic [ROOT_W:0]   sh;
            logic              ge;
            if (s == 0) begin
               rem_prev = e_n_ff[l][NUM_W-1:QUO_W];
               w_prev   = e_n_ff[l][QUO_W-1:0];
               g_prev   = e_g_ff;
            end else begin
               rem_prev = rem_ff[s-1][l];
               w_prev   = w_ff[s-1][l];
               g_prev   = g_ff[s-1];
            end
            // w drains dividend bits from the top and fills quotient bits from the bottom
            sh = {rem_prev, w_prev[QUO_W-1]};
            ge = sh >= {1'b0, g_prev};
            if (ge) begin
               rem_in[s][l] = ROOT_W'(sh - {1'b0, g_prev});
            end else begin
               rem_in[s][l] = sh[ROOT_W-1:0];
            end
            w_in[s][l] = {w_prev[QUO_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
         v_ff   <= '0;
      end else begin
         e_v_ff <= in_valid;
         v_ff   <= {v_ff[QUO_W-2:0], e_v_ff};
      end
      // add half the divisor so the quotient rounds half away from zero
      for (int l = 0; l < LANES; l++) begin
         e_n_ff[l] <= in_side.num[l] + NUM_W'(in_root >> 1);
      end
      e_g_ff             <= in_root;
      e_side_ff.neg      <= in_side.neg;
      e_side_ff.lp       <= in_side.lp;
      e_side_ff.fb       <= in_side.fb;
      e_side_ff.fallback <= in_side.on_axis || (in_root == '0);
      for (int s = 0; s < QUO_W; s++) begin
         for (int l = 0; l < LANES; l++) begin
            rem_ff[s][l] <= rem_in[s][l];
            w_ff[s][l]   <= w_in[s][l];
         end
         if (s == 0) begin
            g_ff[s]    <= e_g_ff;
            side_ff[s] <= e_side_ff;
         end else begin
            g_ff[s]    <= g_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_comb begin
      out_valid = v_ff[QUO_W-1];
      out_side  = side_ff[QUO_W-1];
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = w_ff[QUO_W-1][l];
      end
   end

endmodule

[sv/nearest_point_on_line_circle_plane.sv]
// Top level: register file, pipeline hookup, result select and saturation.
//
//   channel   ports                               beat taken when
//   --------  ----------------------------------  ------------------------
//   request   start, busy, req_data               start && !busy
//   response  rsp_valid, rsp_data                 rsp_valid (no back-pressure)
//   config    csr_we, csr_addr, csr_wdata         csr_we
//
// One point enters every cycle while busy is low; each result leaves through 7 projection
// stages, 32 square-root stages (one root bit each), 21 divider stages (entry plus one
// quotient bit each) and the output register.
// Reset clears the valid pipe and loads the register defaults; busy is reset
// delayed through one register, low otherwise. The pipe never stalls.
module nearest_point_on_line_circle_plane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  npl_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output npl_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [npl_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [npl_pkg::PACK_W-1:0]        csr_wdata
);
   import npl_pkg::*;

   localparam int PIPE_LAT = PROJ_STAGES + ROOT_W + 1 + QUO_W + 1;
   localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((2 ** (COORD_W - 1)) - 1);
   localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;

   logic    busy_ff;
   cfg_type cfg_ff;
   logic    req_accept;

   logic                          prj_valid;
   logic [M_W-1:0]                prj_m;
   sqrt_side_type                 prj_side;
   logic                          sq_valid;
   logic [ROOT_W-1:0]             sq_root;
   sqrt_side_type                 sq_side;
   logic                          dv_valid;
   logic [LANES-1:0][QUO_W-1:0]   dv_quo;
   div_side_type                  dv_side;

   logic signed [RES_W-1:0]   res_sel [LANES];
   logic signed [COORD_W-1:0] res_clip [LANES];
   logic                      sat_any;
   logic [STATUS_W-1:0]       status_in;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;

   assign req_accept = start && !busy_ff;
   assign busy       = busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         cfg_ff.kind   <= KIND_NONE;
         cfg_ff.origin <= '0;
         cfg_ff.axis   <= '0;
         cfg_ff.xaxis  <= '0;
         cfg_ff.radius <= '0;
         cfg_ff.thr    <= THR_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_KIND:   cfg_ff.kind   <= csr_wdata[KIND_W-1:0];
            CSR_ORIGIN: cfg_ff.origin <= csr_wdata;
            CSR_AXIS:   cfg_ff.axis   <= csr_wdata;
            CSR_XAXIS:  cfg_ff.xaxis  <= csr_wdata;
            CSR_RADIUS: cfg_ff.radius <= csr_wdata[RADIUS_W-1:0];
            CSR_THR:    cfg_ff.thr    <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   npl_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (prj_valid),
      .out_m     (prj_m),
      .out_side  (prj_side)
   );

   npl_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prj_valid),
      .in_rad    ({prj_m, {(2 * NORM_GUARD){1'b0}}}),
      .in_side   (prj_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   npl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   always_comb begin
      sat_any = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         logic signed [RES_W-1:0] qv;
         logic signed [RES_W-1:0] circ;
         qv   = RES_W'({1'b0, dv_quo[l]});
         circ = RES_W'($signed(cfg_ff.origin[l*COORD_W +: COORD_W]))
              + (dv_side.neg[l] ? -qv : qv);
         case (cfg_ff.kind) inside
            KIND_LINE, KIND_PLANE: res_sel[l] = $signed(dv_side.lp[l]);
            KIND_CIRCLE: res_sel[l] = dv_side.fallback ? $signed(dv_side.fb[l]) : circ;
            default:     res_sel[l] = '0;
         endcase
         // clamp to the coordinate range
         if (res_sel[l] > RES_MAX) begin
            res_clip[l] = RES_MAX[COORD_W-1:0];
            sat_any     = 1'b1;
         end else if (res_sel[l] < RES_MIN) begin
            res_clip[l] = RES_MIN[COORD_W-1:0];
            sat_any     = 1'b1;
         end else begin
            res_clip[l] = res_sel[l][COORD_W-1:0];
         end
      end
      if (sat_any) begin
         status_in = ST_SAT;
      end else if (cfg_ff.kind == KIND_NONE) begin
         status_in = ST_UNSUP;
      end else if (cfg_ff.kind == KIND_CIRCLE && dv_side.fallback) begin
         status_in = ST_ONAXIS;
      end else begin
         status_in = ST_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
      rsp_data_ff.near_x <= res_clip[0];
      rsp_data_ff.near_y <= res_clip[1];
      rsp_data_ff.near_z <= res_clip[2];
      rsp_data_ff.status <= status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, PIPE_LAT))
      else $error("result beat without a matching request beat");

   a_unsup_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_UNSUP) |->
      (rsp_data.near_x == '0 && rsp_data.near_y == '0 && rsp_data.near_z == '0))
      else $error("unsupported kind gave a nonzero point");

   a_sat_edge : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_SAT) |->
      (rsp_data.near_x == RES_MAX[COORD_W-1:0] || rsp_data.near_x == RES_MIN[COORD_W-1:0] ||
       rsp_data.near_y == RES_MAX[COORD_W-1:0] || rsp_data.near_y == RES_MIN[COORD_W-1:0] ||
       rsp_data.near_z == RES_MAX[COORD_W-1:0] || rsp_data.near_z == RES_MIN[COORD_W-1:0]))
      else $error("saturated status without a clamped coordinate");
`endif

endmodule
